### hdl/msw_pkg.sv
// Shared types, codes and constants of the multi-slot software watchdog.
`default_nettype none

package msw_pkg;

  // Default number of slots in the table
  localparam int unsigned MAX_SLOTS_DEF = 16;

  // Field widths
  localparam int unsigned OP_W       = 3;
  localparam int unsigned ID_W       = 8;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned TIMEOUT_W  = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // Opcodes
  localparam logic [OP_W-1:0] OP_REQUEST = 3'd0;
  localparam logic [OP_W-1:0] OP_ENABLE  = 3'd1;
  localparam logic [OP_W-1:0] OP_DISABLE = 3'd2;
  localparam logic [OP_W-1:0] OP_KICK    = 3'd3;
  localparam logic [OP_W-1:0] OP_CHECK   = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  // Slot id that means "none"
  localparam logic [ID_W-1:0] NO_SLOT = 8'hFF;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 1'b1;

  // Configuration reset values
  localparam logic [COUNT_W-1:0]   SLOT_COUNT_RST = 5'd16;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST    = 16'd1000;

  // Slot mode
  typedef enum logic [1:0] {
    MODE_FREE     = 2'd0,
    MODE_DISABLED = 2'd1,
    MODE_ENABLED  = 2'd2
  } mode_e;

  // One entry of the slot table
  typedef struct packed {
    mode_e             mode;
    logic [TIME_W-1:0] stamp;
  } slot_entry_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LOOKUP,
    S_UPDATE
  } fsm_state_e;

endpackage

`default_nettype wire

### hdl/msw_slot_ram.sv
// Slot table memory: one write and one registered read port, per-entry valid bits.
`default_nettype none

module msw_slot_ram #(
  parameter int unsigned DEPTH = msw_pkg::MAX_SLOTS_DEF,
  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 we_i,
  input  wire logic [IW-1:0]        waddr_i,
  input  wire msw_pkg::slot_entry_t wdata_i,
  input  wire logic [IW-1:0]        raddr_i,
  output msw_pkg::slot_entry_t      rdata_o
);
  import msw_pkg::*;

  slot_entry_t      mem_q [DEPTH];
  slot_entry_t      rd_q;
  logic [DEPTH-1:0] valid_q;
  logic             rd_vld_q;

  // Write and read the storage array
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_q <= mem_q[raddr_i];
  end

  // Track written entries; an unwritten entry reads as free with a zero stamp
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      rd_vld_q <= valid_q[raddr_i];
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire

### hdl/msw_ctrl.sv
// Sequencer with the shared elapsed-time subtract and compare unit.
`default_nettype none

module msw_ctrl #(
  parameter int unsigned MAX_SLOTS = msw_pkg::MAX_SLOTS_DEF,
  localparam int unsigned IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start,
  input  wire logic [msw_pkg::OP_W-1:0]         opcode_i,
  input  wire logic [msw_pkg::ID_W-1:0]         slot_id_i,
  input  wire logic [msw_pkg::TIME_W-1:0]       now_ms_i,
  input  wire logic [msw_pkg::COUNT_W-1:0]      slot_count_i,
  input  wire logic [msw_pkg::TIMEOUT_W-1:0]    timeout_ms_i,
  output logic                                  busy,
  output logic                                  done_o,
  output logic [msw_pkg::ID_W-1:0]              result_slot_o,
  output logic [msw_pkg::STATUS_W-1:0]          status_o,
  output logic                                  ram_we_o,
  output logic [IW-1:0]                         ram_waddr_o,
  output msw_pkg::slot_entry_t                  ram_wdata_o,
  output logic [IW-1:0]                         ram_raddr_o,
  input  wire msw_pkg::slot_entry_t             ram_rdata_i
);
  import msw_pkg::*;

  localparam int unsigned CW = $clog2(MAX_SLOTS + 1);

  fsm_state_e          state_q, state_d;
  logic [OP_W-1:0]     op_q, op_d;
  logic [ID_W-1:0]     id_q, id_d;
  logic [TIME_W-1:0]   now_q, now_d;
  logic [CW-1:0]       n_q, n_d;
  logic [CW-1:0]       rd_idx_q, rd_idx_d;
  logic                ev_vld_q, ev_vld_d;
  logic [IW-1:0]       ev_idx_q, ev_idx_d;
  logic                hit_q, hit_d;
  logic [IW-1:0]       hit_idx_q, hit_idx_d;
  logic [ID_W-1:0]     res_q, res_d;
  logic [STATUS_W-1:0] st_q, st_d;
  logic                done_q, done_d;

  logic [8:0]          count_ext;
  logic [8:0]          n_ext;
  logic                id_out_of_range;
  logic                issue;
  logic [TIME_W-1:0]   elapsed;
  logic                timed_out;

  // Effective slot count, capped at the table depth
  assign count_ext       = 9'(slot_count_i);
  assign n_ext           = (count_ext > 9'(MAX_SLOTS)) ? 9'(MAX_SLOTS) : count_ext;
  assign id_out_of_range = ({1'b0, slot_id_i} >= n_ext);

  // Shared unit: wrapping elapsed time and timeout compare
  assign elapsed   = now_q - ram_rdata_i.stamp;
  assign timed_out = (elapsed > TIME_W'(timeout_ms_i));

  assign issue = (rd_idx_q < n_q);

  // Next state and memory control
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    id_d        = id_q;
    now_d       = now_q;
    n_d         = n_q;
    rd_idx_d    = rd_idx_q;
    ev_vld_d    = 1'b0;
    ev_idx_d    = ev_idx_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    res_d       = res_q;
    st_d        = st_q;
    done_d      = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = ev_idx_q;
    ram_wdata_o = ram_rdata_i;
    ram_raddr_o = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d     = opcode_i;
          id_d     = slot_id_i;
          now_d    = now_ms_i;
          n_d      = CW'(n_ext);
          rd_idx_d = '0;
          hit_d    = 1'b0;
          res_d    = NO_SLOT;
          st_d     = STATUS_OK;
          priority if (opcode_i == OP_REQUEST || opcode_i == OP_CHECK) begin
            state_d = S_SCAN;
          end else if (opcode_i == OP_ENABLE || opcode_i == OP_DISABLE ||
                       opcode_i == OP_KICK) begin
            if (id_out_of_range) begin
              st_d   = STATUS_RANGE;
              done_d = 1'b1;
            end else begin
              state_d = S_LOOKUP;
            end
          end else begin
            // Unused opcode: answer at once
            done_d = 1'b1;
          end
        end
      end

      S_SCAN: begin
        // Issue the next slot read
        if (issue) begin
          ram_raddr_o = rd_idx_q[IW-1:0];
          rd_idx_d    = rd_idx_q + 1'b1;
          ev_vld_d    = 1'b1;
          ev_idx_d    = rd_idx_q[IW-1:0];
        end
        // Evaluate the slot read in the previous cycle
        if (ev_vld_q) begin
          if (op_q == OP_REQUEST) begin
            if (ram_rdata_i.mode == MODE_FREE) begin
              ram_we_o          = 1'b1;
              ram_waddr_o       = ev_idx_q;
              ram_wdata_o.mode  = MODE_DISABLED;
              ram_wdata_o.stamp = now_q;
              res_d             = ID_W'(ev_idx_q);
              st_d              = STATUS_OK;
              done_d            = 1'b1;
              ev_vld_d          = 1'b0;
              state_d           = S_IDLE;
            end
          end else if (ram_rdata_i.mode == MODE_ENABLED && timed_out) begin
            hit_d     = 1'b1;
            hit_idx_d = ev_idx_q;
          end
        end else if (!issue) begin
          // Scan exhausted
          done_d  = 1'b1;
          state_d = S_IDLE;
          if (op_q == OP_REQUEST) begin
            res_d = NO_SLOT;
            st_d  = STATUS_FULL;
          end else begin
            res_d = hit_q ? ID_W'(hit_idx_q) : NO_SLOT;
            st_d  = STATUS_OK;
          end
        end
      end

      S_LOOKUP: begin
        ram_raddr_o = id_q[IW-1:0];
        state_d     = S_UPDATE;
      end

      S_UPDATE: begin
        // Modify the looked-up entry and write it back
        ram_we_o    = 1'b1;
        ram_waddr_o = id_q[IW-1:0];
        priority if (op_q == OP_ENABLE) begin
          ram_wdata_o.mode = MODE_ENABLED;
        end else if (op_q == OP_DISABLE) begin
          ram_wdata_o.mode = MODE_DISABLED;
        end else begin
          ram_wdata_o.stamp = now_q;
        end
        done_d  = 1'b1;
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      rd_idx_q <= '0;
      ev_vld_q <= 1'b0;
      hit_q    <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_idx_q <= rd_idx_d;
      ev_vld_q <= ev_vld_d;
      hit_q    <= hit_d;
      done_q   <= done_d;
    end
  end

  // Hold the transaction payload and result
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    id_q      <= id_d;
    now_q     <= now_d;
    n_q       <= n_d;
    ev_idx_q  <= ev_idx_d;
    hit_idx_q <= hit_idx_d;
    res_q     <= res_d;
    st_q      <= st_d;
  end

  assign busy          = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign result_slot_o = res_q;
  assign status_o      = st_q;

endmodule

`default_nettype wire

### hdl/multi_slot_software_watchdog.sv
// Check and request scan the slots in use; enable, disable and kick read the entry in a
// lookup state and write it back in an update state; out-of-range ids and unused opcodes
// are answered from idle. Throughput: one transaction at a time, busy while the sequencer
// works, walking the slot memory one entry per cycle through its single read port; results cannot stall.
// Reset: all slots free with zero stamps through per-entry valid bits, no clearing
// pass; slot_count resets to 16 and timeout_ms to 1000.
`default_nettype none

module multi_slot_software_watchdog #(
  parameter int unsigned MAX_SLOTS = msw_pkg::MAX_SLOTS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [msw_pkg::OP_W-1:0]           opcode_i,
  input  wire logic [msw_pkg::ID_W-1:0]           slot_id_i,
  input  wire logic [msw_pkg::TIME_W-1:0]         now_ms_i,
  output logic                                    done_o,
  output logic [msw_pkg::ID_W-1:0]                result_slot_o,
  output logic [msw_pkg::STATUS_W-1:0]            status_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [msw_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [msw_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import msw_pkg::*;

  localparam int unsigned IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  logic [COUNT_W-1:0]   slot_count_q;
  logic [TIMEOUT_W-1:0] timeout_q;

  logic                 ram_we;
  logic [IW-1:0]        ram_waddr;
  slot_entry_t          ram_wdata;
  logic [IW-1:0]        ram_raddr;
  slot_entry_t          ram_rdata;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= SLOT_COUNT_RST;
      timeout_q    <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SLOT_COUNT: slot_count_q <= cfg_data_i[COUNT_W-1:0];
        CFG_TIMEOUT:    timeout_q    <= cfg_data_i[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and elapsed-time unit
  msw_ctrl #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .opcode_i      (opcode_i),
    .slot_id_i     (slot_id_i),
    .now_ms_i      (now_ms_i),
    .slot_count_i  (slot_count_q),
    .timeout_ms_i  (timeout_q),
    .busy          (busy),
    .done_o        (done_o),
    .result_slot_o (result_slot_o),
    .status_o      (status_o),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata)
  );

  // Slot table
  msw_slot_ram #(
    .DEPTH (MAX_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // An accepted transaction either finishes at once or keeps the block busy
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted transaction neither busy nor done");

  // The sequencer is back in idle when a result goes out
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while still busy");

  // A full table or an out-of-range id never names a slot
  a_fail_no_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == STATUS_FULL || status_o == STATUS_RANGE))
      |-> (result_slot_o == NO_SLOT))
    else $error("failing status with a slot id");

  // A named slot lies inside the slots in use
  a_slot_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_slot_o != NO_SLOT)
      |-> ((9'(result_slot_o) < 9'(slot_count_q)) && (9'(result_slot_o) < 9'(MAX_SLOTS))))
    else $error("result slot beyond slots in use");

endmodule

`default_nettype wire

### verif/multi_slot_software_watchdog_tb.sv
// Self-checking testbench for the multi-slot software watchdog: directed and random commands.
module multi_slot_software_watchdog_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import msw_pkg::*;

  // Opcodes the block must ignore
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 195;
  localparam int unsigned EMPTY_ITEMS  = 20;
  localparam int unsigned REPORT_LIMIT = 10;

  // One predicted result
  typedef struct packed {
    logic [ID_W-1:0]     slot;
    logic [STATUS_W-1:0] status;
  } wd_result_t;

  // Slot table tracker: applies accepted commands and checks the block's answers
  class watchdog_tracker;
    mode_e               slot_mode [MAX_SLOTS_DEF];
    logic [TIME_W-1:0]   slot_stamp [MAX_SLOTS_DEF];
    logic [COUNT_W-1:0]  slot_count;
    logic [TIMEOUT_W-1:0] timeout_ms;
    wd_result_t          owed_results [$];
    int unsigned         mismatches;
    int unsigned         n_checked;
    int unsigned         n_grants;
    int unsigned         n_refused;
    int unsigned         n_range;
    int unsigned         n_timeouts;

    function new();
      slot_count = SLOT_COUNT_RST;
      timeout_ms = TIMEOUT_RST;
      for (int i = 0; i < MAX_SLOTS_DEF; i++) begin
        slot_mode[i]  = MODE_FREE;
        slot_stamp[i] = '0;
      end
    endfunction

    function void set_config(logic [COUNT_W-1:0] count, logic [TIMEOUT_W-1:0] limit_ms);
      slot_count = count;
      timeout_ms = limit_ms;
    endfunction

    function int unsigned active_slots();
      return (slot_count > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF : int'(slot_count);
    endfunction

    // Update the table for one accepted transaction and queue its answer
    function void apply_command(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                logic [TIME_W-1:0] now);
      int unsigned       n;
      int unsigned       i;
      wd_result_t        r;
      logic [TIME_W-1:0] elapsed;
      n        = active_slots();
      r.slot   = NO_SLOT;
      r.status = STATUS_OK;
      case (op)
        OP_REQUEST: begin
          r.status = STATUS_FULL;
          for (i = 0; i < n; i++) begin
            if (slot_mode[i] == MODE_FREE) begin
              slot_mode[i]  = MODE_DISABLED;
              slot_stamp[i] = now;
              r.slot        = ID_W'(i);
              r.status      = STATUS_OK;
              break;
            end
          end
          if (r.status == STATUS_OK) n_grants++;
          else n_refused++;
        end
        OP_ENABLE, OP_DISABLE, OP_KICK: begin
          if (int'(id) >= n) begin
            r.status = STATUS_RANGE;
            n_range++;
          end else if (op == OP_ENABLE) begin
            slot_mode[id] = MODE_ENABLED;
          end else if (op == OP_DISABLE) begin
            slot_mode[id] = MODE_DISABLED;
          end else begin
            slot_stamp[id] = now;
          end
        end
        OP_CHECK: begin
          // Keep the highest enabled slot past its deadline
          for (i = 0; i < n; i++) begin
            elapsed = now - slot_stamp[i];
            if (slot_mode[i] == MODE_ENABLED && elapsed > TIME_W'(timeout_ms))
              r.slot = ID_W'(i);
          end
          if (r.slot != NO_SLOT) n_timeouts++;
        end
        default: ;
      endcase
      owed_results.push_back(r);
    endfunction

    function void flag(string field, int unsigned want, int unsigned got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("MISMATCH %s: expected %0d, got %0d", field, want, got);
    endfunction

    // Compare one finished transaction against the oldest owed answer
    function void check_result(logic [ID_W-1:0] slot, logic [STATUS_W-1:0] status);
      wd_result_t want;
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("MISMATCH unexpected result: slot %0d status %0d", slot, status);
        return;
      end
      want = owed_results.pop_front();
      n_checked++;
      if (slot !== want.slot) flag("result_slot", want.slot, slot);
      if (status !== want.status) flag("status", want.status, status);
    endfunction
  endclass

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  start      = 1'b0;
  logic                  busy;
  logic [OP_W-1:0]       opcode_i   = OP_CHECK;
  logic [ID_W-1:0]       slot_id_i  = '0;
  logic [TIME_W-1:0]     now_ms_i   = '0;
  logic                  done_o;
  logic [ID_W-1:0]       result_slot_o;
  logic [STATUS_W-1:0]   status_o;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = CFG_SLOT_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  watchdog_tracker tracker;
  int unsigned     n_sent;
  int unsigned     n_settings;

  multi_slot_software_watchdog u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .opcode_i      (opcode_i),
    .slot_id_i     (slot_id_i),
    .now_ms_i      (now_ms_i),
    .done_o        (done_o),
    .result_slot_o (result_slot_o),
    .status_o      (status_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 250 MHz clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Score each finished transaction, then log the newly accepted one
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) tracker.check_result(result_slot_o, status_o);
      if (start && !busy) tracker.apply_command(opcode_i, slot_id_i, now_ms_i);
    end
  end

  // Abort a hung run
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Verification failed");
    $finish;
  end

  // Hold one command until accepted, then idle for the given gap
  task automatic send(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                      input logic [TIME_W-1:0] now, input int unsigned gap);
    start     <= 1'b1;
    opcode_i  <= op;
    slot_id_i <= id;
    now_ms_i  <= now;
    do @(posedge clk_i); while (busy);
    n_sent++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop sending and wait until every owed answer is back and the block is idle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (tracker.owed_results.size() != 0 || busy) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Write both registers back to back
  task automatic configure(input logic [COUNT_W-1:0] count,
                           input logic [TIMEOUT_W-1:0] limit_ms);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_SLOT_COUNT;
    cfg_data_i <= CFG_DATA_W'(count);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_TIMEOUT;
    cfg_data_i <= limit_ms;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    tracker.set_config(count, limit_ms);
    n_settings++;
  endtask

  // Mostly short gaps, a few long ones; dense phases send with no gap
  function automatic int unsigned pick_gap(input bit dense);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (dense || roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 14) return OP_REQUEST;
    if (roll < 32) return OP_ENABLE;
    if (roll < 42) return OP_DISABLE;
    if (roll < 68) return OP_KICK;
    if (roll < 95) return OP_CHECK;
    return OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
  endfunction

  initial begin
    logic [TIME_W-1:0]    clock_ms;
    logic [COUNT_W-1:0]   count;
    logic [TIMEOUT_W-1:0] limit_ms;
    logic [ID_W-1:0]      id;
    int unsigned          n_items;
    int unsigned          step;
    int unsigned          roll;
    bit                   dense;

    tracker    = new();
    n_sent     = 0;
    n_settings = 0;

    // Hold reset, then release it
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: default registers, table starts all free
    send(OP_CHECK,    8'd0,   32'd0,          0);
    send(OP_REQUEST,  8'd0,   32'd5,          1);
    send(OP_ENABLE,   8'd0,   32'd0,          0);
    send(OP_KICK,     8'd0,   32'd100,        0);
    send(OP_CHECK,    8'd0,   32'd1100,       2);
    send(OP_CHECK,    8'd0,   32'd1101,       0);
    send(OP_DISABLE,  8'd0,   32'd1200,       0);
    send(OP_ENABLE,   8'd15,  32'd1300,       0);
    send(OP_CHECK,    8'd0,   32'hFFFF_FFFF,  0);
    send(OP_KICK,     8'd16,  32'd1400,       0);
    send(OP_KICK,     8'hFF,  32'hFFFF_FFFF,  0);
    send(OP_SPARE_LO, 8'hFF,  32'hAAAA_5555,  0);
    send(OP_SPARE_HI, 8'h5A,  32'h5555_AAAA,  1);
    send(OP_REQUEST,  8'hFF,  32'd7000,       0);
    send(OP_KICK,     8'd15,  32'hFFFF_FF00,  0);
    send(OP_CHECK,    8'd0,   32'h0000_00F0,  0);

    // Directed: two slots and a zero timeout, then no slots at all
    drain();
    configure(5'd2, 16'd0);
    send(OP_REQUEST,  8'd0,   32'd7000,       0);
    send(OP_ENABLE,   8'd1,   32'd7000,       0);
    send(OP_CHECK,    8'd0,   32'd7000,       0);
    send(OP_CHECK,    8'd0,   32'd7001,       0);
    send(OP_ENABLE,   8'd2,   32'd7001,       0);
    drain();
    configure(5'd0, 16'hFFFF);
    send(OP_REQUEST,  8'd0,   32'd8000,       0);
    send(OP_KICK,     8'd0,   32'd8000,       0);
    send(OP_CHECK,    8'd0,   32'd8000,       0);

    // Random phases, each under its own register setting
    clock_ms = 32'd9000;
    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase)
        0: begin count = 5'd1;  limit_ms = 16'd1;    end
        1: begin count = 5'd3;  limit_ms = 16'd50;   end
        2: begin count = 5'd16; limit_ms = 16'hFFFF; end
        3: begin count = 5'd0;  limit_ms = 16'd300;  end
        4: begin count = 5'd31; limit_ms = 16'd700;  end
        default: begin
          count    = COUNT_W'($urandom_range(1, 16));
          limit_ms = ($urandom_range(0, 4) == 0) ? 16'd0 : TIMEOUT_W'($urandom_range(1, 3000));
        end
      endcase
      configure(count, limit_ms);
      dense   = (phase == 2 || phase == 5);
      n_items = (count == 0) ? EMPTY_ITEMS : PHASE_ITEMS;
      step    = int'(limit_ms) / 6 + 2;

      for (int k = 0; k < n_items; k++) begin
        // Advance time mostly in small steps, sometimes jump anywhere or near the wrap
        roll = $urandom_range(0, 99);
        if (roll < 3) clock_ms = $urandom;
        else if (roll < 5) clock_ms = 32'hFFFF_FFFF - TIME_W'($urandom_range(0, 2 * step));
        else clock_ms = clock_ms + TIME_W'($urandom_range(0, step));

        // Aim mostly at slots in use, sometimes anywhere
        if (tracker.active_slots() != 0 && $urandom_range(0, 99) < 85)
          id = ID_W'($urandom_range(0, tracker.active_slots() - 1));
        else
          id = ID_W'($urandom_range(0, 255));

        send(pick_op(), id, clock_ms, pick_gap(dense));

        // Occasionally let everything drain mid-phase
        if ($urandom_range(0, 99) < 2) drain();
      end
    end

    // Wait out the last transaction
    drain();
    repeat (24) @(posedge clk_i);

    $display("Ran %0d commands under %0d register settings; %0d answers checked.",
             n_sent, n_settings + 1, tracker.n_checked);
    $display("Seen: %0d grants, %0d refused requests, %0d out-of-range ids, %0d timeouts.",
             tracker.n_grants, tracker.n_refused, tracker.n_range, tracker.n_timeouts);
    if (tracker.mismatches == 0 && tracker.owed_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
